FILE: hdl/pok_pkg.sv
// Shared types, coefficient tables and arithmetic step functions of the OKLab converter.
`timescale 1ns / 1ps
package pok_pkg;

    typedef struct packed {
        logic [7:0]      alpha;
        logic [2:0][7:0] chan;
    } pok_bytes_t;

    typedef struct packed {
        logic [7:0]       alpha;
        logic [2:0][15:0] val;
    } pok_words_t;

    typedef enum logic [1:0] {
        MODE_DIV,
        MODE_SAT,
        MODE_ZERO
    } pok_div_mode_t;

    typedef struct packed {
        logic [15:0] rem;
        logic [7:0]  quot;
    } pok_div_t;

    typedef struct packed {
        logic [15:0] r;
        logic [31:0] r2;
        logic [47:0] r3;
    } pok_cbrt_t;

    typedef logic [255:0][15:0] pok_lin_table_t;

    localparam int LMS_COEF [3][3] = '{
        '{27015, 35149, 3372},
        '{13887, 44610, 7038},
        '{5787, 18463, 41286}
    };

    localparam int LAB_COEF [3][3] = '{
        '{13792, 52011, -267},
        '{129630, -159160, 29530},
        '{1698, 51300, -52997}
    };

    // sRGB decode of one byte to Q0.16, evaluated at elaboration only
    function automatic logic [15:0] lin_entry(input int unsigned i);
        longint unsigned p;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned t;
        longint unsigned y;
        longint unsigned lin;
        if (i <= 10)
        begin
            return 16'((i * 655360 + 16473) / 32946);
        end
        p = 64'(1000 * i + 14025);
        x = ((p << 32) + 64'd134512) / 64'd269025;
        if (x > 64'hFFFF_FFFF)
        begin
            x = 64'hFFFF_FFFF;
        end
        x2 = (x * x) >> 32;
        lo = 0;
        hi = 64'hFFFF_FFFF;
        for (int n = 0; n < 40; n++)
        begin
            if (lo < hi)
            begin
                mid = lo + (hi - lo + 1) / 2;
                t = (mid * mid) >> 32;
                t = (t * mid) >> 32;
                t = (t * mid) >> 32;
                t = (t * mid) >> 32;
                if (t <= x2)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 1;
                end
            end
        end
        y = (x2 * lo) >> 32;
        lin = (y + 64'd32768) >> 16;
        if (lin > 64'd65535)
        begin
            lin = 64'd65535;
        end
        return 16'(lin);
    endfunction

    function automatic pok_lin_table_t build_lin_table();
        pok_lin_table_t tbl;
        for (int i = 0; i < 256; i++)
        begin
            tbl[i] = lin_entry(i);
        end
        return tbl;
    endfunction

    localparam pok_lin_table_t LIN_TABLE = build_lin_table();

    // one restoring division step at quotient bit b
    function automatic pok_div_t div_step(input pok_div_t s, input logic [7:0] d, input int b);
        pok_div_t    o;
        logic [15:0] sh;
        o = s;
        sh = 16'({8'b0, d} << b);
        if (s.rem >= sh)
        begin
            o.rem = s.rem - sh;
            o.quot[b] = 1'b1;
        end
        return o;
    endfunction

    // try bit b of the root, keeping r^2 and r^3 current
    function automatic pok_cbrt_t cbrt_step(input pok_cbrt_t s, input logic [15:0] v,
                                            input int b);
        pok_cbrt_t   o;
        logic [49:0] t2;
        logic [49:0] t1;
        logic [49:0] t0;
        logic [49:0] cand;
        o = s;
        t2 = (50'(s.r2) + (50'(s.r2) << 1)) << b;
        t1 = (50'(s.r) + (50'(s.r) << 1)) << (2 * b);
        t0 = 50'(1) << (3 * b);
        cand = 50'(s.r3) + t2 + t1 + t0;
        if (cand <= {2'b0, v, 32'b0})
        begin
            o.r3 = 48'(cand);
            o.r2 = s.r2 + (32'(s.r) << (b + 1)) + (32'(1) << (2 * b));
            o.r[b] = 1'b1;
        end
        return o;
    endfunction

endpackage

FILE: hdl/pok_unpremul.sv
// Pipelined un-premultiply of three colour bytes against alpha, two quotient bits per stage.
`timescale 1ns / 1ps
module pok_unpremul
    import pok_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  pok_bytes_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output pok_bytes_t out_data
);

    localparam int STAGES = 4;

    logic          vld_reg  [STAGES];
    pok_div_t      div_reg  [STAGES][3];
    pok_div_mode_t mode_reg [STAGES][3];
    logic [7:0]    alpha_reg[STAGES];
    logic [STAGES:0] en;

    pok_div_t      div_in  [3];
    pok_div_mode_t mode_in [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            div_in[c].rem  = ({in_data.chan[c], 8'b0} - {8'b0, in_data.chan[c]})
                             + {9'b0, in_data.alpha[7:1]};
            div_in[c].quot = '0;
            if (in_data.alpha == 8'd0)
            begin
                mode_in[c] = MODE_ZERO;
            end
            else if (in_data.chan[c] >= in_data.alpha)
            begin
                mode_in[c] = MODE_SAT;
            end
            else
            begin
                mode_in[c] = MODE_DIV;
            end
        end
    end

    assign en[STAGES] = out_ready;
    assign in_ready   = en[0];

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        pok_div_t      src_div  [3];
        pok_div_mode_t src_mode [3];
        logic [7:0]    src_alpha;
        logic          src_vld;
        pok_div_t      div_next [3];

        assign en[g] = !vld_reg[g] || en[g + 1];

        if (g == 0)
        begin : g_first
            assign src_div   = div_in;
            assign src_mode  = mode_in;
            assign src_alpha = in_data.alpha;
            assign src_vld   = in_valid;
        end
        else
        begin : g_rest
            assign src_div   = div_reg[g - 1];
            assign src_mode  = mode_reg[g - 1];
            assign src_alpha = alpha_reg[g - 1];
            assign src_vld   = vld_reg[g - 1];
        end

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                div_next[c] = div_step(div_step(src_div[c], src_alpha, 7 - 2 * g),
                                       src_alpha, 6 - 2 * g);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en[g])
            begin
                vld_reg[g] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                div_reg[g]   <= div_next;
                mode_reg[g]  <= src_mode;
                alpha_reg[g] <= src_alpha;
            end
        end
    end

    assign out_valid      = vld_reg[STAGES - 1];
    assign out_data.alpha = alpha_reg[STAGES - 1];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            unique case (mode_reg[STAGES - 1][c])
                MODE_ZERO: out_data.chan[c] = 8'd0;
                MODE_SAT:  out_data.chan[c] = 8'd255;
                default:   out_data.chan[c] = div_reg[STAGES - 1][c].quot;
            endcase
        end
    end

    // transparent pixels decode to black
    a_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.alpha == 8'd0 |-> out_data.chan == '0)
        else $error("nonzero colour for zero alpha");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> in_ready)
        else $error("input stalled with empty first stage");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_reg[STAGES - 1][0] == MODE_DIV
        |-> div_reg[STAGES - 1][0].rem < {8'b0, out_data.alpha})
        else $error("division remainder not below divisor");

endmodule

FILE: hdl/pok_cbrt.sv
// Pipelined digit-by-digit Q0.16 cube root on three lanes, two root bits per stage.
`timescale 1ns / 1ps
module pok_cbrt
    import pok_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  pok_words_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output pok_words_t out_data
);

    localparam int STAGES = 8;

    logic        vld_reg  [STAGES];
    pok_cbrt_t   st_reg   [STAGES][3];
    logic [15:0] v_reg    [STAGES][3];
    logic [7:0]  alpha_reg[STAGES];
    logic [STAGES:0] en;

    assign en[STAGES] = out_ready;
    assign in_ready   = en[0];

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        pok_cbrt_t   src_st [3];
        logic [15:0] src_v  [3];
        logic [7:0]  src_alpha;
        logic        src_vld;
        pok_cbrt_t   st_next[3];

        assign en[g] = !vld_reg[g] || en[g + 1];

        if (g == 0)
        begin : g_first
            for (genvar c = 0; c < 3; c++)
            begin : g_lane
                assign src_st[c] = '0;
                assign src_v[c]  = in_data.val[c];
            end
            assign src_alpha = in_data.alpha;
            assign src_vld   = in_valid;
        end
        else
        begin : g_rest
            assign src_st    = st_reg[g - 1];
            assign src_v     = v_reg[g - 1];
            assign src_alpha = alpha_reg[g - 1];
            assign src_vld   = vld_reg[g - 1];
        end

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                st_next[c] = cbrt_step(cbrt_step(src_st[c], src_v[c], 15 - 2 * g),
                                       src_v[c], 14 - 2 * g);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en[g])
            begin
                vld_reg[g] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                st_reg[g]    <= st_next;
                v_reg[g]     <= src_v;
                alpha_reg[g] <= src_alpha;
            end
        end
    end

    assign out_valid      = vld_reg[STAGES - 1];
    assign out_data.alpha = alpha_reg[STAGES - 1];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            out_data.val[c] = st_reg[STAGES - 1][c].r;
        end
    end

    a_cube_fits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> st_reg[STAGES - 1][0].r3 <= {v_reg[STAGES - 1][0], 32'b0})
        else $error("root cube exceeds target");

    a_square_track: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && st_reg[STAGES - 1][1].r == 16'd0 |-> st_reg[STAGES - 1][1].r2 == '0)
        else $error("root square out of step");

    a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && v_reg[STAGES - 1][2] == 16'd0 |-> out_data.val[2] == 16'd0)
        else $error("nonzero root of zero");

endmodule

FILE: hdl/premultiplied_rgba_to_oklab.sv
// Top level: premultiplied RGBA stream in, OKLab stream out.
`timescale 1ns / 1ps
// Converts one premultiplied RGBA pixel per clock to OKLab (L, a, b at a scale of 4096,
// alpha passed through). Every part is fully pipelined, so a pixel is accepted in every
// cycle while the output side takes results. The path holds 17 register stages: four
// un-premultiply divider stages (two quotient bits each), the sRGB decode table, two LMS
// stages, eight cube-root stages (two root bits each), two Lab stages. Each stage holds
// its item while the next is full, and bubbles close up, so a stall on the output loses
// or repeats nothing. No clearing pass follows reset.
module premultiplied_rgba_to_oklab
    import pok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // lightness[12:0], green_red[24:13], blue_yellow[36:25],
                                   // alpha_out[44:37], zero[47:45]
);

    pok_bytes_t in_bytes;
    pok_bytes_t div_data;
    logic       div_valid;
    logic       div_ready;

    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic        e1, e2, e3, e4, e5;
    pok_words_t  lin_reg;
    logic [31:0] lms_prod_reg[3][3];
    logic [7:0]  alpha2_reg;
    pok_words_t  lms_reg;
    pok_words_t  root_data;
    logic        root_valid;
    logic        root_ready;
    logic        cbrt_in_ready;
    logic signed [35:0] lab_prod_reg[3][3];
    logic [7:0]  alpha4_reg;
    logic [12:0] light_reg;
    logic [11:0] gr_reg;
    logic [11:0] by_reg;
    logic [7:0]  alpha5_reg;

    pok_words_t  lin_next;
    pok_words_t  lms_next;
    logic [12:0] light_next;
    logic [11:0] gr_next;
    logic [11:0] by_next;

    assign in_bytes.chan[0] = s_tdata[7:0];
    assign in_bytes.chan[1] = s_tdata[15:8];
    assign in_bytes.chan[2] = s_tdata[23:16];
    assign in_bytes.alpha   = s_tdata[31:24];

    pok_unpremul u_unpremul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_bytes),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    assign e5         = !v5_reg || m_tready;
    assign e4         = !v4_reg || e5;
    assign root_ready = e4;
    assign e3         = !v3_reg || cbrt_in_ready;
    assign e2         = !v2_reg || e3;
    assign e1         = !v1_reg || e2;
    assign div_ready  = e1;

    always_comb
    begin
        lin_next.alpha = div_data.alpha;
        for (int c = 0; c < 3; c++)
        begin
            lin_next.val[c] = LIN_TABLE[div_data.chan[c]];
        end
    end

    // sum the LMS row, round, clamp to Q0.16
    always_comb
    begin
        logic [33:0] acc;
        logic [17:0] sh;
        lms_next.alpha = alpha2_reg;
        for (int k = 0; k < 3; k++)
        begin
            acc = 34'(lms_prod_reg[k][0]) + 34'(lms_prod_reg[k][1])
                + 34'(lms_prod_reg[k][2]) + 34'd32768;
            sh = acc[33:16];
            lms_next.val[k] = (sh > 18'd65535) ? 16'hFFFF : sh[15:0];
        end
    end

    // sum the Lab rows, round half away from zero to 1/4096, saturate
    always_comb
    begin
        logic signed [37:0] acc;
        logic [37:0]        mag;
        logic [17:0]        rm;
        logic signed [18:0] val [3];
        for (int k = 0; k < 3; k++)
        begin
            acc = 38'(lab_prod_reg[k][0]) + 38'(lab_prod_reg[k][1])
                + 38'(lab_prod_reg[k][2]);
            mag = acc[37] ? 38'(-acc) : 38'(acc);
            rm  = 18'((mag + 38'd524288) >> 20);
            val[k] = acc[37] ? -$signed({1'b0, rm}) : $signed({1'b0, rm});
        end
        if (val[0] < 0)
        begin
            light_next = 13'd0;
        end
        else if (val[0] > 19'sd4096)
        begin
            light_next = 13'd4096;
        end
        else
        begin
            light_next = val[0][12:0];
        end
        gr_next = (val[1] < -19'sd2048) ? 12'h800 :
                  (val[1] > 19'sd2047)  ? 12'h7FF : val[1][11:0];
        by_next = (val[2] < -19'sd2048) ? 12'h800 :
                  (val[2] > 19'sd2047)  ? 12'h7FF : val[2][11:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (e1)
            begin
                v1_reg <= div_valid;
            end
            if (e2)
            begin
                v2_reg <= v1_reg;
            end
            if (e3)
            begin
                v3_reg <= v2_reg;
            end
            if (e4)
            begin
                v4_reg <= root_valid;
            end
            if (e5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (e1)
        begin
            lin_reg <= lin_next;
        end
        if (e2)
        begin
            alpha2_reg <= lin_reg.alpha;
            for (int k = 0; k < 3; k++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    lms_prod_reg[k][c] <= 32'(lin_reg.val[c]) * 32'(LMS_COEF[k][c]);
                end
            end
        end
        if (e3)
        begin
            lms_reg <= lms_next;
        end
        if (e4)
        begin
            alpha4_reg <= root_data.alpha;
            for (int k = 0; k < 3; k++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    lab_prod_reg[k][c] <= 36'($signed({1'b0, root_data.val[c]})
                                              * $signed(19'(LAB_COEF[k][c])));
                end
            end
        end
        if (e5)
        begin
            light_reg  <= light_next;
            gr_reg     <= gr_next;
            by_reg     <= by_next;
            alpha5_reg <= alpha4_reg;
        end
    end

    pok_cbrt u_cbrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_ready  (cbrt_in_ready),
        .in_data   (lms_reg),
        .out_valid (root_valid),
        .out_ready (root_ready),
        .out_data  (root_data)
    );

    assign m_tvalid = v5_reg;
    assign m_tdata  = {3'b000, alpha5_reg, by_reg, gr_reg, light_reg};

    a_light_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[12:0] <= 13'd4096)
        else $error("lightness above full scale");

    a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[44:37] == 8'd0 |-> m_tdata[36:0] == '0)
        else $error("transparent pixel not black");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tdata[47:45] == 3'b000)
        else $error("pad bits set");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output empty");

endmodule

FILE: verif/premultiplied_rgba_to_oklab_checker.sv
// Checker for the OKLab converter: predicts each pixel's result and compares output transfers.
`timescale 1ns / 1ps
module premultiplied_rgba_to_oklab_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // lightness[12:0], green_red[24:13], blue_yellow[36:25],
                                   // alpha_out[44:37], zero[47:45]
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [7:0]  alpha_out;
        logic [11:0] blue_yellow;
        logic [11:0] green_red;
        logic [12:0] lightness;
    } lab_pixel_t;

    localparam longint MIX_LMS [3][3] = '{
        '{27015, 35149, 3372}, '{13887, 44610, 7038}, '{5787, 18463, 41286}};
    localparam longint MIX_LAB [3][3] = '{
        '{13792, 52011, -267}, '{129630, -159160, 29530}, '{1698, 51300, -52997}};

    lab_pixel_t      lab_queue[$];
    longint unsigned decode_lut[256];

    function automatic longint unsigned pow5_q32(input longint unsigned r);
        longint unsigned t;
        t = (r * r) >> 32;
        t = (t * r) >> 32;
        t = (t * r) >> 32;
        t = (t * r) >> 32;
        return t;
    endfunction

    function automatic longint unsigned srgb_decode(input int unsigned i);
        longint unsigned p, x, x2, lo, hi, mid, lin;
        if (i <= 10)
        begin
            return (i * 655360 + 16473) / 32946;
        end
        p = 1000 * i + 14025;
        x = ((p << 32) + 134512) / 269025;
        if (x > 64'hFFFF_FFFF)
        begin
            x = 64'hFFFF_FFFF;
        end
        x2 = (x * x) >> 32;
        lo = 0;
        hi = 64'hFFFF_FFFF;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            if (pow5_q32(mid) <= x2)
                lo = mid;
            else
                hi = mid - 1;
        end
        lin = (((x2 * lo) >> 32) + 32768) >> 16;
        return (lin > 65535) ? 65535 : lin;
    endfunction

    function automatic longint unsigned cube_root(input longint unsigned v);
        longint unsigned tgt, lo, hi, mid;
        tgt = v << 32;
        lo = 0;
        hi = 65535;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            if (mid * mid * mid <= tgt)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic lab_pixel_t convert_pixel(input logic [31:0] px);
        int unsigned     a, s;
        longint unsigned lin[3], root[3];
        longint          acc, lab[3];
        lab_pixel_t      res;
        a = px[31:24];
        for (int c = 0; c < 3; c++)
        begin
            s = 0;
            if (a != 0)
            begin
                s = (px[8*c +: 8] * 255 + a / 2) / a;
                if (s > 255)
                    s = 255;
            end
            lin[c] = decode_lut[s];
        end
        for (int k = 0; k < 3; k++)
        begin
            acc = 0;
            for (int c = 0; c < 3; c++)
                acc += MIX_LMS[k][c] * longint'(lin[c]);
            acc = (acc + 32768) / 65536;
            root[k] = cube_root(longint'(clip(acc, 0, 65535)));
        end
        for (int k = 0; k < 3; k++)
        begin
            acc = 0;
            for (int c = 0; c < 3; c++)
                acc += MIX_LAB[k][c] * longint'(root[c]);
            // round half away from zero
            if (acc >= 0)
                lab[k] = (acc + (1 << 19)) >>> 20;
            else
                lab[k] = -((-acc + (1 << 19)) >>> 20);
        end
        res.lightness   = 13'(clip(lab[0], 0, 4096));
        res.green_red   = 12'(clip(lab[1], -2048, 2047));
        res.blue_yellow = 12'(clip(lab[2], -2048, 2047));
        res.alpha_out   = 8'(a);
        return res;
    endfunction

    initial
    begin
        for (int i = 0; i < 256; i++)
            decode_lut[i] = srgb_decode(i);
    end

    assign pending = lab_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        lab_pixel_t want, got;
        if (!rst_n)
        begin
            errors <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                lab_queue = {lab_queue, convert_pixel(s_tdata)};
            if (m_tvalid && m_tready)
            begin
                got = lab_pixel_t'(m_tdata[44:0]);
                if (lab_queue.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected output transfer %h", m_tdata);
                    errors <= errors + 1;
                end
                else
                begin
                    want = lab_queue.pop_front();
                    if (got !== want || m_tdata[47:45] !== 3'b0)
                    begin
                        if (errors < 10)
                            $display("mismatch: exp L=%0d a=%0d b=%0d alpha=%0d, got %h",
                                     want.lightness, $signed(want.green_red),
                                     $signed(want.blue_yellow), want.alpha_out, m_tdata);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: verif/premultiplied_rgba_to_oklab_tb.sv
// Testbench top: drives pixels into the OKLab converter and reports the verdict.
`timescale 1ns / 1ps
module premultiplied_rgba_to_oklab_tb;

    localparam int LATENCY   = 17;
    localparam int WATCHDOG  = 5000;
    localparam int RANDOM_PX = 430;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    int          errors;
    int          pending;
    int          idle_cycles;
    bit          sending_done;
    bit          hold_off;
    logic [31:0] pixel_list[$];

    premultiplied_rgba_to_oklab DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    premultiplied_rgba_to_oklab_checker checker_inst
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] make_pixel(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b, input logic [7:0] a);
        return {a, b, g, r};
    endfunction

    // mostly valid premultiplied pixels, some with color above alpha
    function automatic logic [31:0] random_pixel();
        logic [7:0] a;
        int         k;
        k = $urandom_range(0, 9);
        a = (k == 0) ? 8'd255 : ((k == 1) ? 8'd0 : 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) < 7)
            return make_pixel(8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
                              8'($urandom_range(0, a)), a);
        return $urandom();
    endfunction

    // sender
    initial
    begin
        int gap;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        sending_done = 1'b0;
        pixel_list = '{
            make_pixel(0, 0, 0, 0), make_pixel(255, 255, 255, 0),
            make_pixel(0, 0, 0, 255), make_pixel(255, 255, 255, 255),
            make_pixel(255, 0, 0, 255), make_pixel(0, 255, 0, 255),
            make_pixel(0, 0, 255, 255), make_pixel(255, 255, 0, 255),
            make_pixel(0, 255, 255, 255), make_pixel(255, 0, 255, 255),
            make_pixel(200, 10, 90, 1), make_pixel(255, 255, 255, 1),
            make_pixel(1, 1, 1, 1), make_pixel(128, 64, 32, 128),
            make_pixel(10, 11, 12, 255), make_pixel(11, 10, 9, 255),
            make_pixel(255, 128, 0, 100), make_pixel(170, 85, 255, 85),
            make_pixel(1, 2, 3, 254), make_pixel(85, 170, 42, 170)
        };
        for (int i = 0; i < RANDOM_PX; i++)
            pixel_list = {pixel_list, random_pixel()};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (pixel_list[i])
        begin
            gap = gap_length();
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= pixel_list[i];
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
        end
        s_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    // receiver, with one long hold-off so the pipeline backs up
    initial
    begin
        int gap;
        m_tready = 1'b0;
        hold_off = 1'b0;
        @(posedge rst_n);
        repeat (30) @(posedge clk);
        hold_off = 1'b1;
        repeat (120) @(posedge clk);
        hold_off = 1'b0;
        forever
        begin
            gap = gap_length();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // watchdog on transfer activity
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        @(posedge rst_n);
        fork
            begin
                wait (sending_done);
                @(posedge clk);
                wait (pending == 0);
                repeat (LATENCY + 10) @(posedge clk);
            end
            begin
                wait (idle_cycles >= WATCHDOG);
            end
        join_any
        if (idle_cycles < WATCHDOG && errors == 0 && pending == 0)
            $display("premultiplied_rgba_to_oklab_tb OK");
        else
            $display("premultiplied_rgba_to_oklab_tb NOT OK");
        $finish;
    end

endmodule

FILE: files.f
hdl/pok_pkg.sv
hdl/pok_unpremul.sv
hdl/pok_cbrt.sv
hdl/premultiplied_rgba_to_oklab.sv
verif/premultiplied_rgba_to_oklab_checker.sv
verif/premultiplied_rgba_to_oklab_tb.sv
